FILE: sv/button_debounce_hold_detector_macros.svh
// Assertion macros of the button debounce and hold detector RTL, used by bdh_core.
// Self-contained; take it in with an include of the bare file name.
`ifndef BUTTON_DEBOUNCE_HOLD_DETECTOR_MACROS_SVH
`define BUTTON_DEBOUNCE_HOLD_DETECTOR_MACROS_SVH

// Check an expression at every rising clock edge outside reset.
`define BDH_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("bdh assertion failed");

// Check that a condition is followed by a consequence in the next cycle.
`define BDH_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bdh assertion failed");

`endif

FILE: sv/bdh_pkg.sv
// Shared types and constants of the button debounce and hold detector.
// No dependencies; every module of the block imports it.
package bdh_pkg;

   localparam int unsigned DEBOUNCE_W = 16;
   localparam int unsigned TIME_W     = 32;
   localparam int unsigned ANALOG_W   = 10;
   localparam int unsigned CSR_ADDR_W = 2;
   localparam int unsigned CSR_DATA_W = 32;
   localparam int unsigned REQ_DATA_W = 48;
   localparam int unsigned RSP_DATA_W = 8;

   // Analog samples strictly above this read as a high level
   localparam logic [ANALOG_W-1:0] ANALOG_THRESHOLD = 10'd512;

   localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd50;
   localparam logic [TIME_W-1:0]     HOLD_RESET     = 32'd500;

   // Configuration register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_DEBOUNCE_MS  = 2'd0,
      REG_HOLD_MS      = 2'd1,
      REG_INVERT_LEVEL = 2'd2,
      REG_USE_ANALOG   = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic [DEBOUNCE_W-1:0] debounce_ms;
      logic [TIME_W-1:0]     hold_ms;
      logic                  invert_level;
      logic                  use_analog;
   } cfg_type;

   // Qualified poll handed from the input stage to the core
   typedef struct packed {
      logic              raw;
      logic [TIME_W-1:0] now_ms;
   } poll_type;

   // Result fields, first field in the highest bit
   typedef struct packed {
      logic hold_start_event;
      logic release_event;
      logic press_event;
      logic held;
      logic pressed;
   } result_type;

endpackage

FILE: sv/button_debounce_hold_detector.sv
// Path: a poll beat is registered in the input stage and then in the result register, from which
// its result beat is handed over on the result channel.
// Throughput: one poll per cycle while the result channel does not stall; the debounce and hold
// timers update through three 32-bit subtract-and-compare paths side by side.
// Reset: synchronous, active high; clears the timers, the debounced and held state,
// both stage valids, and loads the register defaults (debounce 50 ms, hold 500 ms).
module button_debounce_hold_detector
   import bdh_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Poll channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // digital_level, analog_level[9:0], now_ms[31:0], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // Result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // pressed, held, press_event, release_event, hold_start_event, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // Register write port
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type  cfg;
   poll_type poll;
   logic     poll_valid;
   logic     poll_take;

   bdh_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bdh_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .poll_valid (poll_valid),
      .poll       (poll),
      .poll_take  (poll_take)
   );

   bdh_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .poll_valid (poll_valid),
      .poll       (poll),
      .poll_take  (poll_take),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

FILE: sv/bdh_csr.sv
// Configuration registers of the button debounce and hold detector.
// Depends on bdh_pkg for the register indexes and the cfg_type struct.
module bdh_csr
   import bdh_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write into the addressed register
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (reg_index_type'(csr_addr))
            REG_DEBOUNCE_MS:  cfg_in.debounce_ms  = csr_wdata[DEBOUNCE_W-1:0];
            REG_HOLD_MS:      cfg_in.hold_ms      = csr_wdata[TIME_W-1:0];
            REG_INVERT_LEVEL: cfg_in.invert_level = csr_wdata[0];
            REG_USE_ANALOG:   cfg_in.use_analog   = csr_wdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms  <= DEBOUNCE_RESET;
         cfg_ff.hold_ms      <= HOLD_RESET;
         cfg_ff.invert_level <= 1'b0;
         cfg_ff.use_analog   <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

FILE: sv/bdh_in_stage.sv
// Input register: takes one poll beat, derives the raw level and holds it.
// Depends on bdh_pkg for widths, the analog threshold and poll_type.
module bdh_in_stage
   import bdh_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  poll_valid,
   output poll_type              poll,
   input  logic                  poll_take
);

   logic                valid_ff;
   logic                valid_in;
   poll_type            poll_ff;
   logic                digital_level;
   logic [ANALOG_W-1:0] analog_level;
   logic [TIME_W-1:0]   now_ms;
   logic                level;

   // Unpack the beat
   assign digital_level = req_tdata[0];
   assign analog_level  = req_tdata[ANALOG_W:1];
   assign now_ms        = req_tdata[ANALOG_W+TIME_W:ANALOG_W+1];

   // Pick the level source, then apply the polarity
   assign level = cfg.use_analog ? (analog_level > ANALOG_THRESHOLD) : digital_level;

   // Accept whenever the stage is empty or drains this cycle
   assign req_tready = !valid_ff || poll_take;

   always_comb begin
      valid_in = valid_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Hold the payload until the core takes it
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         poll_ff.raw    <= level ^ cfg.invert_level;
         poll_ff.now_ms <= now_ms;
      end
   end

   assign poll_valid = valid_ff;
   assign poll       = poll_ff;

endmodule

FILE: sv/bdh_core.sv
// Debounce and hold state, and the result register of the detector.
// Depends on bdh_pkg and on button_debounce_hold_detector_macros.svh.
`include "button_debounce_hold_detector_macros.svh"
module bdh_core
   import bdh_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  poll_valid,
   input  poll_type              poll,
   output logic                  poll_take,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata
);

   logic              last_raw_ff, last_raw_in;
   logic              pressed_ff, pressed_in;
   logic              held_ff, held_in;
   logic [TIME_W-1:0] press_start_ff, press_start_in;
   logic [TIME_W-1:0] release_start_ff, release_start_in;
   logic [TIME_W-1:0] hold_start_ff, hold_start_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        result_ff, result_in;
   logic [TIME_W-1:0] press_elapsed;
   logic [TIME_W-1:0] release_elapsed;
   logic [TIME_W-1:0] hold_elapsed;
   logic              debounce_done_press;
   logic              debounce_done_release;
   logic              hold_done;
   logic              advance;

   // Advance when a poll waits and the result register is free or drains
   assign advance   = poll_valid && (!rsp_valid_ff || rsp_tready);
   assign poll_take = advance;

   // Elapsed times wrap modulo 2^32
   assign press_elapsed   = poll.now_ms - press_start_ff;
   assign release_elapsed = poll.now_ms - release_start_ff;
   assign hold_elapsed    = poll.now_ms - hold_start_ff;
   assign debounce_done_press   = press_elapsed >= TIME_W'(cfg.debounce_ms);
   assign debounce_done_release = release_elapsed >= TIME_W'(cfg.debounce_ms);
   assign hold_done             = hold_elapsed >= cfg.hold_ms;

   // Next debounce and hold state for the current poll
   always_comb begin
      last_raw_in      = last_raw_ff;
      pressed_in       = pressed_ff;
      held_in          = held_ff;
      press_start_in   = press_start_ff;
      release_start_in = release_start_ff;
      hold_start_in    = hold_start_ff;
      if (advance) begin
         last_raw_in = poll.raw;
         // Restart the timer on a new level, qualify on a repeated one
         if (poll.raw) begin
            if (!last_raw_ff) begin
               press_start_in = poll.now_ms;
            end else if (debounce_done_press) begin
               pressed_in = 1'b1;
            end
         end else begin
            if (last_raw_ff) begin
               release_start_in = poll.now_ms;
            end else if (debounce_done_release) begin
               pressed_in = 1'b0;
            end
         end
         // Hold timer starts on the poll on which the press qualifies
         if (pressed_in) begin
            if (!pressed_ff) begin
               hold_start_in = poll.now_ms;
            end else if (hold_done) begin
               held_in = 1'b1;
            end
         end else begin
            held_in = 1'b0;
         end
      end
   end

   // Result of the current poll
   always_comb begin
      result_in.pressed          = pressed_in;
      result_in.held             = held_in;
      result_in.press_event      = pressed_in && !pressed_ff;
      result_in.release_event    = !pressed_in && pressed_ff;
      result_in.hold_start_event = held_in && !held_ff;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_raw_ff      <= 1'b0;
         pressed_ff       <= 1'b0;
         held_ff          <= 1'b0;
         press_start_ff   <= '0;
         release_start_ff <= '0;
         hold_start_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         last_raw_ff      <= last_raw_in;
         pressed_ff       <= pressed_in;
         held_ff          <= held_in;
         press_start_ff   <= press_start_in;
         release_start_ff <= release_start_in;
         hold_start_ff    <= hold_start_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Load the result beat
   always_ff @(posedge clock) begin
      if (advance) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - $bits(result_type)){1'b0}}, result_ff};

   `BDH_ASSERT_ALWAYS(a_held_needs_pressed, clock, reset, !held_ff || pressed_ff)
   `BDH_ASSERT_NEXT(a_advance_loads_result, clock, reset, advance, rsp_valid_ff)
   `BDH_ASSERT_ALWAYS(a_events_exclusive, clock, reset,
      !rsp_valid_ff || !(result_ff.press_event && result_ff.release_event))
   `BDH_ASSERT_ALWAYS(a_hold_event_held, clock, reset,
      !rsp_valid_ff || !result_ff.hold_start_event || result_ff.held)

endmodule
